// ===== rtl/core/bitmap_block_allocator_macros.svh =====
// Assertion macros shared by the bitmap block allocator RTL.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bba_pkg.sv =====
// Shared constants and types of the bitmap block allocator.
package bba_pkg;

  localparam int MAP_BYTES_DEFAULT = 2048;
  localparam int WORD_BYTES        = 8;
  localparam int WORD_BITS         = WORD_BYTES * 8;
  localparam int LANE_W            = $clog2(WORD_BYTES);
  localparam int POS_W             = $clog2(WORD_BITS);
  localparam int BIT_W             = 3;
  localparam int BLOCK_SHIFT       = 2;
  localparam int MAP_WORDS_DEFAULT = (MAP_BYTES_DEFAULT + WORD_BYTES - 1) / WORD_BYTES;

  localparam logic [31:0] BASE_RESET  = 32'd2;
  localparam logic [11:0] SIZE_RESET  = 12'd2048;
  localparam logic [32:0] BASE_OFFSET = 33'd4;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_BASE = 1'b0,
    CFG_SIZE = 1'b1
  } cfg_reg_t;

endpackage

// ===== rtl/core/bba_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module bba_ram #(
  parameter int WIDTH = bba_pkg::WORD_BITS,
  parameter int DEPTH = bba_pkg::MAP_WORDS_DEFAULT
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/bitmap_block_allocator.sv =====
// Top level of the first-fit bitmap block allocator.
//
//   channel | handshake              | payload
//   --------+------------------------+----------------------------------
//   in      | in_valid / in_stall    | cmd, block_in, byte_index, byte_in
//   out     | out_valid / out_stall  | block_out, status, byte_out
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Release, load and read pass through the issue, modify and finish states
// before a result waits; a rejected block number or byte index skips modify.
// Allocate passes through issue, a scan of 64-bit bitmap words and finish; the scan
// starts at a hint word below which every word is known to be full.
// After reset a clearing pass writes every bitmap word (MAP_BYTES/8 rounded up,
// 256 by default) with in_stall high; config writes go on.
// One item is in work at a time; the next is accepted while a result waits
// under out_stall.
`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator #(
  parameter int MAP_BYTES = bba_pkg::MAP_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] block_in,
  input  logic [10:0] byte_index,
  input  logic [7:0]  byte_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] block_out,
  output logic [1:0]  status,
  output logic [7:0]  byte_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int WB    = bba_pkg::WORD_BITS;
  localparam int LW_   = bba_pkg::LANE_W;
  localparam int PW    = bba_pkg::POS_W;
  localparam int WORDS = (MAP_BYTES + bba_pkg::WORD_BYTES - 1) / bba_pkg::WORD_BYTES;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = AW + 1;
  localparam int XW    = AW + 14;
  localparam int LW    = XW + 16;
  localparam logic [XW-1:0] MAP_BYTES_X = XW'(MAP_BYTES);
  localparam logic [AW-1:0] LAST_WORD   = AW'(WORDS - 1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_ISSUE  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_MODIFY = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [32:0] base_lo;
  logic [11:0] map_size;

  logic [AW-1:0] clr_addr;
  logic [CW-1:0] cur_word, cur_word_next;
  logic [CW-1:0] hint, hint_next;
  logic [AW-1:0] op_word, op_word_next;
  logic [PW-1:0] op_pos, op_pos_next;

  bba_pkg::cmd_t cmd_q;
  logic [31:0]   blk_q;
  logic [10:0]   idx_q;
  logic [7:0]    val_q;

  logic [31:0]      res_block, res_block_next;
  bba_pkg::status_t res_status, res_status_next;
  logic [7:0]       res_byte, res_byte_next;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  logic [WB-1:0] mem_wr_data;
  logic [AW-1:0] mem_rd_addr;
  logic [WB-1:0] mem_rd_data;

  logic [XW-1:0]       size_x;
  logic [XW-1:0]       used;
  logic [CW-1:0]       scan_nxt;
  logic                cur_past;
  logic                nxt_past;
  logic [bba_pkg::WORD_BYTES-1:0] lane_used;
  logic [WB-1:0]       scan_free;
  logic [PW-1:0]       free_pos;
  logic [CW+PW-1:0]    alloc_bit;
  logic                rel_below;
  logic [31:0]         rel_diff;
  logic [31-bba_pkg::BLOCK_SHIFT:0] rel_bit;
  logic                rel_in_map;
  logic [XW-1:0]       idx_x;
  logic                idx_ok;
  logic [WB-1:0]       rel_mask;
  logic [WB-1:0]       load_word;
  logic                op_below_hint;

  bba_ram #(
    .WIDTH (WB),
    .DEPTH (WORDS)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // Bytes that take part in allocate and release.
  assign size_x = XW'(map_size);
  assign used   = (size_x > MAP_BYTES_X) ? MAP_BYTES_X : size_x;

  assign scan_nxt = cur_word + CW'(1);
  assign cur_past = (XW'({cur_word, {LW_{1'b0}}}) >= used);
  assign nxt_past = (XW'({scan_nxt, {LW_{1'b0}}}) >= used);

  // Bytes beyond the map size look full to the scan.
  always_comb begin
    for (int j = 0; j < bba_pkg::WORD_BYTES; j++) begin
      lane_used[j] = (XW'({cur_word, LW_'(j)}) < used);
    end
    for (int b = 0; b < WB; b++) begin
      scan_free[b] = lane_used[b >> 3] & ~mem_rd_data[b];
    end
  end

  always_comb begin
    free_pos = '0;
    for (int k = WB - 1; k >= 0; k--) begin
      if (scan_free[k]) begin
        free_pos = PW'(k);
      end
    end
  end

  assign alloc_bit = {cur_word, free_pos};

  assign rel_below  = ({1'b0, blk_q} < base_lo);
  assign rel_diff   = blk_q - base_lo[31:0];
  assign rel_bit    = rel_diff[31:bba_pkg::BLOCK_SHIFT];
  assign rel_in_map = (LW'(rel_bit) < LW'({used, {bba_pkg::BIT_W{1'b0}}}));

  assign idx_x  = XW'(idx_q);
  assign idx_ok = (idx_x < MAP_BYTES_X);

  assign rel_mask      = WB'(1) << op_pos;
  assign op_below_hint = (CW'(op_word) < hint);

  always_comb begin
    load_word = mem_rd_data;
    load_word[{idx_q[LW_-1:0], 3'b000} +: 8] = val_q;
  end

  always_comb begin
    state_next      = state;
    cur_word_next   = cur_word;
    hint_next       = hint;
    op_word_next    = op_word;
    op_pos_next     = op_pos;
    res_block_next  = res_block;
    res_status_next = res_status;
    res_byte_next   = res_byte;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = op_word;
    mem_wr_data     = load_word;
    mem_rd_addr     = op_word;

    case (state)
      S_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = '0;
        if (clr_addr == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cur_word_next = hint;
          state_next    = S_ISSUE;
        end
      end
      S_ISSUE: begin
        res_block_next  = '0;
        res_byte_next   = '0;
        res_status_next = bba_pkg::ST_OK;
        case (cmd_q)
          bba_pkg::CMD_ALLOC: begin
            mem_rd_addr = cur_word[AW-1:0];
            if (cur_past) begin
              res_status_next = bba_pkg::ST_FULL;
              state_next      = S_FINISH;
            end else begin
              state_next = S_SCAN;
            end
          end
          bba_pkg::CMD_RELEASE: begin
            op_word_next = rel_bit[AW+PW-1:PW];
            op_pos_next  = rel_bit[PW-1:0];
            mem_rd_addr  = rel_bit[AW+PW-1:PW];
            if (rel_below || !rel_in_map) begin
              res_status_next = bba_pkg::ST_BAD;
              state_next      = S_FINISH;
            end else begin
              state_next = S_MODIFY;
            end
          end
          bba_pkg::CMD_LOAD, bba_pkg::CMD_READ: begin
            op_word_next = idx_x[AW+LW_-1:LW_];
            mem_rd_addr  = idx_x[AW+LW_-1:LW_];
            if (!idx_ok) begin
              res_status_next = bba_pkg::ST_BAD;
              state_next      = S_FINISH;
            end else begin
              state_next = S_MODIFY;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        // The next word is read ahead; its data is dropped when this one hits.
        mem_rd_addr = scan_nxt[AW-1:0];
        if (|scan_free) begin
          mem_wr_en      = 1'b1;
          mem_wr_addr    = cur_word[AW-1:0];
          mem_wr_data    = mem_rd_data | (WB'(1) << free_pos);
          res_block_next = base_lo[31:0] + (32'(alloc_bit) << bba_pkg::BLOCK_SHIFT);
          state_next     = S_FINISH;
        end else begin
          if (&lane_used) begin
            hint_next = scan_nxt;
          end
          cur_word_next = scan_nxt;
          if (nxt_past) begin
            res_status_next = bba_pkg::ST_FULL;
            state_next      = S_FINISH;
          end
        end
      end
      S_MODIFY: begin
        state_next = S_FINISH;
        case (cmd_q)
          bba_pkg::CMD_RELEASE: begin
            mem_wr_data = mem_rd_data & ~rel_mask;
            if ((mem_rd_data & rel_mask) == '0) begin
              res_status_next = bba_pkg::ST_BAD;
            end else begin
              mem_wr_en = 1'b1;
              if (op_below_hint) begin
                hint_next = CW'(op_word);
              end
            end
          end
          bba_pkg::CMD_LOAD: begin
            mem_wr_en = 1'b1;
            if (op_below_hint) begin
              hint_next = CW'(op_word);
            end
          end
          bba_pkg::CMD_READ: begin
            res_byte_next = mem_rd_data[{idx_q[LW_-1:0], 3'b000} +: 8];
          end
          default: begin
          end
        endcase
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      hint      <= '0;
      out_valid <= 1'b0;
      base_lo   <= {1'b0, bba_pkg::BASE_RESET} + bba_pkg::BASE_OFFSET;
      map_size  <= bba_pkg::SIZE_RESET;
    end else begin
      state <= state_next;
      hint  <= hint_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == S_FINISH && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bba_pkg::CFG_BASE: begin
            base_lo <= {1'b0, cfg_data} + bba_pkg::BASE_OFFSET;
          end
          bba_pkg::CFG_SIZE: begin
            map_size <= cfg_data[11:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_word   <= cur_word_next;
    op_word    <= op_word_next;
    op_pos     <= op_pos_next;
    res_block  <= res_block_next;
    res_status <= res_status_next;
    res_byte   <= res_byte_next;
    if (in_valid && !in_stall) begin
      cmd_q <= bba_pkg::cmd_t'(cmd);
      blk_q <= block_in;
      idx_q <= byte_index;
      val_q <= byte_in;
    end
    if (state == S_FINISH && (!out_valid || !out_stall)) begin
      block_out <= res_block;
      status    <= res_status;
      byte_out  <= res_byte;
    end
  end

  // The scan only ever advances together with the hint word.
  `BBA_ASSERT_NOW(a_scan_at_hint, state == S_SCAN, cur_word == hint, "scan left the hint word")
  `BBA_ASSERT_NOW(a_full_no_block, out_valid && status == bba_pkg::ST_FULL, block_out == 32'd0, "full result carries a block number")
  `BBA_ASSERT_NEXT(a_accept_issue, in_valid && !in_stall, state == S_ISSUE, "accepted item did not enter issue")
  `BBA_ASSERT_NOW(a_write_busy, mem_wr_en, state != S_IDLE && state != S_FINISH, "bitmap written while no item is in work")

endmodule
